// ===== rtl/core/dfma_pkg.sv =====
// Shared types, codes and sine table for the density Fourier mode accumulator.
package dfma_pkg;

    localparam logic ACT_ACC  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam int PHASE_W = 15;
    localparam int TRIG_W  = 17;
    localparam int COUNT_W = 32;
    localparam int MODE_W  = 5;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } t_trig;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic acc_rd;
        logic step_col;
        logic step_row;
        logic clr_wr;
        logic bin_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_action;
        logic out_free;
    } t_stat;

    function automatic logic signed [TRIG_W-1:0] quarter_sine(input logic [5:0] k);
        logic signed [TRIG_W-1:0] v;
        case (k)
            6'd0:  v = 17'sd0;
            6'd1:  v = 17'sd1608;
            6'd2:  v = 17'sd3212;
            6'd3:  v = 17'sd4808;
            6'd4:  v = 17'sd6393;
            6'd5:  v = 17'sd7962;
            6'd6:  v = 17'sd9512;
            6'd7:  v = 17'sd11039;
            6'd8:  v = 17'sd12540;
            6'd9:  v = 17'sd14010;
            6'd10: v = 17'sd15447;
            6'd11: v = 17'sd16846;
            6'd12: v = 17'sd18205;
            6'd13: v = 17'sd19520;
            6'd14: v = 17'sd20788;
            6'd15: v = 17'sd22006;
            6'd16: v = 17'sd23170;
            6'd17: v = 17'sd24279;
            6'd18: v = 17'sd25330;
            6'd19: v = 17'sd26320;
            6'd20: v = 17'sd27246;
            6'd21: v = 17'sd28106;
            6'd22: v = 17'sd28899;
            6'd23: v = 17'sd29622;
            6'd24: v = 17'sd30274;
            6'd25: v = 17'sd30853;
            6'd26: v = 17'sd31357;
            6'd27: v = 17'sd31786;
            6'd28: v = 17'sd32138;
            6'd29: v = 17'sd32413;
            6'd30: v = 17'sd32610;
            6'd31: v = 17'sd32729;
            6'd32: v = 17'sd32768;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    function automatic t_trig sin_cos(input logic [PHASE_W-1:0] phase);
        logic [15:0]              p;
        logic [6:0]               idx;
        logic [1:0]               quad;
        logic [4:0]               r;
        logic signed [TRIG_W-1:0] a;
        logic signed [TRIG_W-1:0] b;
        t_trig                    t;
        p    = {1'b0, phase} + 16'd128;
        idx  = p[14:8];
        quad = idx[6:5];
        r    = idx[4:0];
        a    = quarter_sine({1'b0, r});
        b    = quarter_sine(6'd32 - {1'b0, r});
        case (quad)
            2'd0: begin
                t.s = a;
                t.c = b;
            end
            2'd1: begin
                t.s = b;
                t.c = -a;
            end
            2'd2: begin
                t.s = -a;
                t.c = -b;
            end
            default: begin
                t.s = -b;
                t.c = a;
            end
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/core/dfma_if.sv =====
// Input and result channel interfaces of the density Fourier mode accumulator.
interface dfma_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [4:0]         mode_y;
    logic [4:0]         mode_z;

    modport source(output valid, action, pos_y, pos_z, mode_y, mode_z, input ready);
    modport sink(input valid, action, pos_y, pos_z, mode_y, mode_z, output ready);
endinterface

interface dfma_out_if #(
    parameter int SUM_WIDTH = 48
);
    logic                        valid;
    logic                        ready;
    logic signed [SUM_WIDTH-1:0] sum_real;
    logic signed [SUM_WIDTH-1:0] sum_imag;
    logic [31:0]                 sample_count;
    logic                        saturated;

    modport source(output valid, sum_real, sum_imag, sample_count, saturated, input ready);
    modport sink(input valid, sum_real, sum_imag, sample_count, saturated, output ready);
endinterface

// ===== rtl/core/dfma_ctrl.sv =====
// Sequencer for bin clearing, accumulate sweeps and bin reads.
module dfma_ctrl #(
    parameter int MODES_Y = 20,
    parameter int MODES_Z = 20,
    localparam int ADDR_W = (MODES_Y * MODES_Z > 1) ? $clog2(MODES_Y * MODES_Z) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dfma_pkg::t_stat       i_stat,
    output dfma_pkg::t_cmd        o_cmd,
    output logic [ADDR_W-1:0]     o_addr
);
    localparam int NBINS  = MODES_Y * MODES_Z;
    localparam int COL_W  = (MODES_Z > 1) ? $clog2(MODES_Z) : 1;
    localparam logic [ADDR_W-1:0] LAST_BIN = ADDR_W'(NBINS - 1);
    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(MODES_Z - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_col   = r_col;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (r_addr == LAST_BIN) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_addr        = '0;
                    n_col         = '0;
                    n_state       = (i_stat.in_action == dfma_pkg::ACT_ACC) ? S_ACC : S_RD;
                end
            end
            S_ACC: begin
                o_cmd.acc_rd = 1'b1;
                if (r_col == LAST_COL) begin
                    n_col          = '0;
                    o_cmd.step_row = 1'b1;
                end else begin
                    n_col          = r_col + 1'b1;
                    o_cmd.step_col = 1'b1;
                end
                if (r_addr == LAST_BIN) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_RD: begin
                o_cmd.bin_rd = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_col   <= n_col;
        end
    end

    assign o_addr = r_addr;

endmodule

// ===== rtl/core/dfma_datapath.sv =====
// Bin memory, phase stepping, saturating update pipeline and result register.
module dfma_datapath #(
    parameter int MODES_Y   = 20,
    parameter int MODES_Z   = 20,
    parameter int SUM_WIDTH = 48,
    localparam int ADDR_W   = (MODES_Y * MODES_Z > 1) ? $clog2(MODES_Y * MODES_Z) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dfma_pkg::t_cmd    i_cmd,
    input  logic [ADDR_W-1:0] i_addr,
    output dfma_pkg::t_stat   o_stat,
    dfma_in_if.sink           i_in,
    dfma_out_if.source        o_out
);
    localparam int NBINS  = MODES_Y * MODES_Z;
    localparam int SW     = SUM_WIDTH;
    localparam int WORD_W = 2 * SW + 1;
    localparam int PW     = dfma_pkg::PHASE_W;
    localparam int TW     = dfma_pkg::TRIG_W;
    localparam int CNT_W  = dfma_pkg::COUNT_W;
    localparam logic [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    logic [WORD_W-1:0]          r_mem [NBINS];
    logic [WORD_W-1:0]          r_rd_data;
    logic [PW-1:0]              r_y;
    logic [PW-1:0]              r_z;
    logic [PW-1:0]              r_row_phase;
    logic [PW-1:0]              r_phase;
    logic [dfma_pkg::MODE_W-1:0] r_my;
    logic [dfma_pkg::MODE_W-1:0] r_mz;
    logic [CNT_W-1:0]           r_count;
    logic                       r_wr_en;
    logic [ADDR_W-1:0]          r_wr_addr;
    dfma_pkg::t_trig            r_trig;
    logic                       r_out_valid;
    logic [SW-1:0]              r_out_real;
    logic [SW-1:0]              r_out_imag;
    logic [CNT_W-1:0]           r_out_count;
    logic                       r_out_sat;

    logic                       w_in_range;
    logic [ADDR_W-1:0]          w_read_bin;
    logic                       w_rd_en;
    logic [ADDR_W-1:0]          w_rd_addr;
    logic [SW-1:0]              w_acc_re;
    logic [SW-1:0]              w_acc_im;
    logic [SW:0]                w_full_re;
    logic [SW:0]                w_full_im;
    logic                       w_ovf_re;
    logic                       w_ovf_im;
    logic [SW-1:0]              w_new_re;
    logic [SW-1:0]              w_new_im;
    logic                       w_new_sat;

    assign w_in_range = (32'(r_my) < MODES_Y) && (32'(r_mz) < MODES_Z);
    assign w_read_bin = w_in_range ? ADDR_W'(32'(r_my) * MODES_Z + 32'(r_mz)) : '0;
    assign w_rd_en    = i_cmd.acc_rd | i_cmd.bin_rd;
    assign w_rd_addr  = i_cmd.bin_rd ? w_read_bin : i_addr;

    assign w_acc_re  = r_rd_data[SW-1:0];
    assign w_acc_im  = r_rd_data[2*SW-1:SW];
    assign w_full_re = {w_acc_re[SW-1], w_acc_re} + {{(SW+1-TW){r_trig.c[TW-1]}}, r_trig.c};
    assign w_full_im = {w_acc_im[SW-1], w_acc_im} + {{(SW+1-TW){r_trig.s[TW-1]}}, r_trig.s};
    assign w_ovf_re  = w_full_re[SW] ^ w_full_re[SW-1];
    assign w_ovf_im  = w_full_im[SW] ^ w_full_im[SW-1];
    assign w_new_re  = w_ovf_re ? (w_full_re[SW] ? SUM_MIN : SUM_MAX) : w_full_re[SW-1:0];
    assign w_new_im  = w_ovf_im ? (w_full_im[SW] ? SUM_MIN : SUM_MAX) : w_full_im[SW-1:0];
    assign w_new_sat = r_rd_data[WORD_W-1] | w_ovf_re | w_ovf_im;

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
        if (i_cmd.clr_wr) begin
            r_mem[i_addr] <= '0;
        end else if (r_wr_en) begin
            r_mem[r_wr_addr] <= {w_new_sat, w_new_im, w_new_re};
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= i_addr;
        r_trig    <= dfma_pkg::sin_cos(r_phase);
        if (i_cmd.capture) begin
            r_y         <= i_in.pos_y[PW-1:0];
            r_z         <= i_in.pos_z[PW-1:0];
            r_my        <= i_in.mode_y;
            r_mz        <= i_in.mode_z;
            r_row_phase <= '0;
            r_phase     <= '0;
        end else if (i_cmd.step_row) begin
            r_row_phase <= r_row_phase + r_y;
            r_phase     <= r_row_phase + r_y;
        end else if (i_cmd.step_col) begin
            r_phase <= r_phase + r_z;
        end
        if (i_cmd.out_load) begin
            r_out_real  <= w_in_range ? w_acc_re : '0;
            r_out_imag  <= w_in_range ? w_acc_im : '0;
            r_out_sat   <= w_in_range ? r_rd_data[WORD_W-1] : 1'b0;
            r_out_count <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_en <= i_cmd.acc_rd;
            if (i_cmd.capture && (i_in.action == dfma_pkg::ACT_ACC) && (r_count != '1)) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_in.ready         = i_cmd.in_ready;
    assign o_stat.in_valid    = i_in.valid;
    assign o_stat.in_action   = i_in.action;
    assign o_stat.out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.sum_real     = r_out_real;
    assign o_out.sum_imag     = r_out_imag;
    assign o_out.sample_count = r_out_count;
    assign o_out.saturated    = r_out_sat;

endmodule

// ===== rtl/core/density_fourier_mode_accumulator_top.sv =====
// Top level of the density Fourier mode accumulator.
//
//  channel  dir  modport  payload
//  i_in     in   sink     action, pos_y, pos_z, mode_y, mode_z
//  o_out    out  source   sum_real, sum_imag, sample_count, saturated
//
// After reset, a clearing pass writes zero to every bin, one bin a cycle; no
// transfer is taken on i_in meanwhile.
// An accumulate does one bin read-modify-write a cycle through the bin memory's
// separate read and write ports, with phases stepped by addition.
// A read passes a bin read state, then an output state that waits while the result
// register holds an untaken result; an accumulate may be taken while a result waits on o_out.
module density_fourier_mode_accumulator_top #(
    parameter int MODES_Y   = 20,
    parameter int MODES_Z   = 20,
    parameter int SUM_WIDTH = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dfma_in_if.sink    i_in,
    dfma_out_if.source o_out
);
    localparam int NBINS  = MODES_Y * MODES_Z;
    localparam int ADDR_W = (NBINS > 1) ? $clog2(NBINS) : 1;

    dfma_pkg::t_cmd    w_cmd;
    dfma_pkg::t_stat   w_stat;
    logic [ADDR_W-1:0] w_addr;

    dfma_ctrl #(
        .MODES_Y (MODES_Y),
        .MODES_Z (MODES_Z)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_addr  (w_addr)
    );

    dfma_datapath #(
        .MODES_Y   (MODES_Y),
        .MODES_Z   (MODES_Z),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_addr  (w_addr),
        .o_stat  (w_stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ===== tb/density_mode_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts bin readouts of the density mode accumulator and compares them.
module density_mode_checker #(
    parameter int MODES_Y   = 20,
    parameter int MODES_Z   = 20,
    parameter int SUM_WIDTH = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dfma_in_if   i_in,
    dfma_out_if  i_out,
    output int   o_mismatches,
    output int   o_owed
);
    localparam int TRIG_W  = dfma_pkg::TRIG_W;
    localparam int COUNT_W = dfma_pkg::COUNT_W;
    localparam int PHASE_W = dfma_pkg::PHASE_W;
    localparam int MODE_W  = dfma_pkg::MODE_W;

    localparam int BINS = MODES_Y * MODES_Z;
    localparam logic signed [SUM_WIDTH-1:0] SUM_HI = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_LO = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic signed [TRIG_W-1:0] QUARTER_WAVE [33] = '{
        17'sd0,     17'sd1608,  17'sd3212,  17'sd4808,  17'sd6393,  17'sd7962,
        17'sd9512,  17'sd11039, 17'sd12540, 17'sd14010, 17'sd15447, 17'sd16846,
        17'sd18205, 17'sd19520, 17'sd20788, 17'sd22006, 17'sd23170, 17'sd24279,
        17'sd25330, 17'sd26320, 17'sd27246, 17'sd28106, 17'sd28899, 17'sd29622,
        17'sd30274, 17'sd30853, 17'sd31357, 17'sd31786, 17'sd32138, 17'sd32413,
        17'sd32610, 17'sd32729, 17'sd32768
    };

    typedef struct packed {
        logic signed [TRIG_W-1:0] sine;
        logic signed [TRIG_W-1:0] cosine;
    } t_phasor;

    typedef struct packed {
        logic signed [SUM_WIDTH-1:0] sum_real;
        logic signed [SUM_WIDTH-1:0] sum_imag;
        logic [COUNT_W-1:0]          count;
        logic                        saturated;
    } t_readout;

    logic signed [SUM_WIDTH-1:0] real_sums [BINS];
    logic signed [SUM_WIDTH-1:0] imag_sums [BINS];
    logic                        clamped [BINS];
    logic [COUNT_W-1:0]          positions_taken;
    t_readout                    owed_readouts [$];
    int                          mismatches = 0;
    int                          owed_count = 0;

    assign o_mismatches = mismatches;
    assign o_owed       = owed_count;

    function automatic t_phasor lookup_phasor(input logic [PHASE_W-1:0] phase);
        logic [PHASE_W:0]         rounded;
        logic [1:0]               quadrant;
        int                       step;
        logic signed [TRIG_W-1:0] rising;
        logic signed [TRIG_W-1:0] falling;
        t_phasor                  pv;
        rounded  = {1'b0, phase} + 16'd128;
        quadrant = rounded[14:13];
        step     = int'(rounded[12:8]);
        rising   = QUARTER_WAVE[step];
        falling  = QUARTER_WAVE[32 - step];
        case (quadrant)
            2'd0:    pv = '{rising, falling};
            2'd1:    pv = '{falling, -rising};
            2'd2:    pv = '{-rising, -falling};
            default: pv = '{-falling, rising};
        endcase
        return pv;
    endfunction

    function automatic logic signed [SUM_WIDTH-1:0] clamp_add(
        input  logic signed [SUM_WIDTH-1:0] sum,
        input  logic signed [TRIG_W-1:0]    delta,
        output logic                        hit
    );
        logic signed [SUM_WIDTH:0] wide;
        wide = sum + delta;
        hit  = 1'b0;
        if (wide > SUM_HI) begin
            hit = 1'b1;
            return SUM_HI;
        end
        if (wide < SUM_LO) begin
            hit = 1'b1;
            return SUM_LO;
        end
        return wide[SUM_WIDTH-1:0];
    endfunction

    task automatic accumulate_position(input logic [15:0] y, input logic [15:0] z);
        int unsigned turns;
        int unsigned b;
        t_phasor     pv;
        logic        hit_r;
        logic        hit_i;
        for (int unsigned qy = 0; qy < MODES_Y; qy++) begin
            for (int unsigned qz = 0; qz < MODES_Z; qz++) begin
                turns        = qy * y + qz * z;
                b            = qy * MODES_Z + qz;
                pv           = lookup_phasor(turns[PHASE_W-1:0]);
                real_sums[b] = clamp_add(real_sums[b], pv.cosine, hit_r);
                imag_sums[b] = clamp_add(imag_sums[b], pv.sine, hit_i);
                clamped[b]   = clamped[b] | hit_r | hit_i;
            end
        end
        if (positions_taken != '1) begin
            positions_taken++;
        end
    endtask

    function automatic t_readout read_bin(input logic [MODE_W-1:0] my,
                                          input logic [MODE_W-1:0] mz);
        t_readout r;
        int       b;
        r       = '0;
        r.count = positions_taken;
        if (int'(my) < MODES_Y && int'(mz) < MODES_Z) begin
            b           = int'(my) * MODES_Z + int'(mz);
            r.sum_real  = real_sums[b];
            r.sum_imag  = imag_sums[b];
            r.saturated = clamped[b];
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input longint want_v,
                                 input longint got_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_readout want;
        if (!i_rst_n) begin
            for (int b = 0; b < BINS; b++) begin
                real_sums[b] = '0;
                imag_sums[b] = '0;
                clamped[b]   = 1'b0;
            end
            positions_taken = '0;
            owed_readouts.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (i_in.action == dfma_pkg::ACT_ACC) begin
                    accumulate_position(i_in.pos_y, i_in.pos_z);
                end else begin
                    owed_readouts.push_back(read_bin(i_in.mode_y, i_in.mode_z));
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (owed_readouts.size() == 0) begin
                    $display("%0t: readout mismatch, expected none, actual real %0d imag %0d",
                             $time, i_out.sum_real, i_out.sum_imag);
                    mismatches++;
                end else begin
                    want = owed_readouts.pop_front();
                    if (i_out.sum_real !== want.sum_real) begin
                        flag_mismatch("sum_real", longint'(want.sum_real),
                                      longint'(i_out.sum_real));
                    end
                    if (i_out.sum_imag !== want.sum_imag) begin
                        flag_mismatch("sum_imag", longint'(want.sum_imag),
                                      longint'(i_out.sum_imag));
                    end
                    if (i_out.sample_count !== want.count) begin
                        flag_mismatch("sample_count", longint'(want.count),
                                      longint'(i_out.sample_count));
                    end
                    if (i_out.saturated !== want.saturated) begin
                        flag_mismatch("saturated", longint'(want.saturated),
                                      longint'(i_out.saturated));
                    end
                end
            end
        end
        owed_count = owed_readouts.size();
    end

endmodule

// ===== tb/density_fourier_mode_accumulator_top_test.sv =====
`timescale 1ns / 1ps
// Stimulus, handshake pacing and verdict for the density Fourier mode accumulator.
module density_fourier_mode_accumulator_top_test;

    localparam int MODES_Y      = 20;
    localparam int MODES_Z      = 20;
    localparam int SUM_WIDTH    = 48;
    localparam int BINS         = MODES_Y * MODES_Z;
    localparam int RANDOM_ITEMS = 1500;
    localparam int MAX_GAP      = 11;
    localparam int QUIET_LIMIT  = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   mismatches;
    int   owed;
    int   quiet_cycles = 0;
    bit   no_gaps = 1'b0;

    dfma_in_if                           in_ch();
    dfma_out_if #(.SUM_WIDTH(SUM_WIDTH)) out_ch();

    density_fourier_mode_accumulator_top #(
        .MODES_Y   (MODES_Y),
        .MODES_Z   (MODES_Z),
        .SUM_WIDTH (SUM_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    density_mode_checker #(
        .MODES_Y   (MODES_Y),
        .MODES_Z   (MODES_Z),
        .SUM_WIDTH (SUM_WIDTH)
    ) mode_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_mismatches (mismatches),
        .o_owed       (owed)
    );

    always #4 i_clk = ~i_clk;

    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic logic [15:0] pick_position();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic act, input logic [15:0] y, input logic [15:0] z,
                             input logic [4:0] my, input logic [4:0] mz);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.pos_y  <= y;
        in_ch.pos_z  <= z;
        in_ch.mode_y <= my;
        in_ch.mode_z <= mz;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_acc(input logic [15:0] y, input logic [15:0] z);
        send_item(dfma_pkg::ACT_ACC, y, z, 5'($urandom), 5'($urandom));
    endtask

    task automatic send_read(input logic [4:0] my, input logic [4:0] mz);
        send_item(dfma_pkg::ACT_READ, 16'($urandom), 16'($urandom), my, mz);
    endtask

    // hold off each result transfer by a random stall
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [4:0] my;
        logic [4:0] mz;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.action <= dfma_pkg::ACT_ACC;
        in_ch.pos_y  <= '0;
        in_ch.pos_z  <= '0;
        in_ch.mode_y <= '0;
        in_ch.mode_z <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_read(5'd0, 5'd0);
        send_read(5'd31, 5'd31);
        send_acc(16'h0000, 16'h0000);
        send_acc(16'h7fff, 16'h7fff);
        send_acc(16'h8000, 16'h8000);
        send_acc(16'hffff, 16'h0001);
        send_acc(16'h007f, 16'h0080);
        send_acc(16'h4000, 16'hc000);
        send_read(5'd0, 5'd0);
        send_read(5'd19, 5'd19);
        send_read(5'd1, 5'd0);
        send_read(5'd0, 5'd1);
        send_read(5'd19, 5'd0);
        send_read(5'd0, 5'd19);
        send_read(5'd20, 5'd0);
        send_read(5'd0, 5'd20);
        send_read(5'd7, 5'd13);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 45) begin
                send_acc(pick_position(), pick_position());
            end else if ($urandom_range(0, 9) == 0) begin
                my = 5'($urandom);
                mz = 5'($urandom);
                if (my < MODES_Y && mz < MODES_Z) begin
                    mz = 5'($urandom_range(MODES_Z, 31));
                end
                send_read(my, mz);
            end else begin
                send_read(5'($urandom_range(0, MODES_Y - 1)),
                          5'($urandom_range(0, MODES_Z - 1)));
            end
        end
        in_ch.valid <= 1'b0;

        while (owed != 0) @(negedge i_clk);
        repeat (BINS + 16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
